FILE: sv/message_fifo_overwrite_oldest_assert.svh
// Assertion macros for the message queue checker.
// Used by mfo_checker; expects clk_i and rst_ni in the scope of use.
`ifndef MESSAGE_FIFO_OVERWRITE_OLDEST_ASSERT_SVH
`define MESSAGE_FIFO_OVERWRITE_OLDEST_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MFO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MFO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mfo_pkg.sv
// Shared types and codes of the message queue.
// No dependencies; imported by every module of the block.
package mfo_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 3;
  localparam int unsigned MSGLEN_W    = 6;
  localparam int unsigned ENTCNT_W    = 4;
  localparam int unsigned OVF_W       = 8;

  typedef enum logic [1:0] {
    FN_PUSH     = 2'd0,
    FN_POP      = 2'd1,
    FN_READ_OVF = 2'd2,
    FN_CLEAR    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_PUSHED   = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_CLEARED  = 3'd4,
    ST_TRUNC    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_LEN   = 2'd1,
    S_BYTES = 2'd2
  } state_e;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic [MSGLEN_W-1:0] msg_length;
    logic                last;
    status_e             status;
    logic [ENTCNT_W-1:0] entry_count;
    logic [OVF_W-1:0]    ovf_count;
  } res_t;

  typedef struct packed {
    logic byte_we;
    logic byte_re;
    logic len_we;
    logic len_re;
  } mem_ctl_t;

endpackage

FILE: sv/message_fifo_overwrite_oldest.sv
// Message queue that drops its oldest entry when a push begins on a full queue.
// Depends on mfo_pkg, mfo_store and mfo_resq.
//
//   port group  dir  tdata                    tuser              tlast
//   s_axis      in   data_byte                func, has_byte     last_byte
//   m_axis      out  out_byte .. ovf_count    status             last_result
//
// Push, read-overflow, clear and an empty pop are each answered straight from idle.
// A pop of n bytes does one length memory read, then one byte memory read per byte,
// issued back to back while the result queue has room, and ends when the last byte
// lands; a message with no bytes writes its word once its length has been read.
// No new word is taken while a pop streams; reset needs no clearing pass.
// A stalled output holds the result queue, which in turn holds the pop sequencer.
module message_fifo_overwrite_oldest import mfo_pkg::*; #(
  parameter int unsigned DEPTH     = 8,
  parameter int unsigned MSG_BYTES = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // [1:0] func, [2] has_byte
  input  logic                   s_axis_tlast,  // last_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] out_byte, [13:8] msg_length, [17:14] entry_count,
  // [25:18] overflow_count, [31:26] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // [2:0] status
  output logic                   m_axis_tlast   // last_result
);

  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned ENT_W  = $clog2(DEPTH + 1);
  localparam int unsigned OFS_W  = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int unsigned LEN_W  = $clog2(MSG_BYTES + 1);
  localparam int unsigned BYTE_AW = SLOT_W + OFS_W;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  state_e             state_q, state_d;
  logic [SLOT_W-1:0]  write_slot_q, write_slot_d;
  logic [SLOT_W-1:0]  read_slot_q, read_slot_d;
  logic [ENT_W-1:0]   entries_q, entries_d;
  logic [OVF_W-1:0]   dropped_q, dropped_d;
  logic [LEN_W-1:0]   push_ofs_q, push_ofs_d;
  logic               push_act_q, push_act_d;
  logic               infl_q, infl_d;
  logic               infl_last_q, infl_last_d;
  logic [SLOT_W-1:0]  pop_slot_q, pop_slot_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LEN_W-1:0]   idx_q, idx_d;

  mem_ctl_t           mem_ctl;
  logic [BYTE_AW-1:0] byte_waddr, byte_raddr;
  logic [7:0]         byte_rdata;
  logic [SLOT_W-1:0]  len_waddr;
  logic [LEN_W-1:0]   len_wdata, len_rdata;

  logic               res_wr, res_valid;
  res_t               res_w, res_r;
  logic [1:0]         res_cnt;
  logic               out_pop, room, accept;
  logic [2:0]         occ;

  func_e              func;
  logic [7:0]         in_byte;
  logic               in_has, in_last;

  assign func    = func_e'(s_axis_tuser[1:0]);
  assign in_has  = s_axis_tuser[2];
  assign in_byte = s_axis_tdata[7:0];
  assign in_last = s_axis_tlast;

  // Room counts queued words plus a byte read still on its way from memory.
  assign out_pop = res_valid & m_axis_tready;
  assign occ     = 3'(res_cnt) + 3'(infl_q) - 3'(out_pop);
  assign room    = (occ < 3'd2);

  assign s_axis_tready = (state_q == S_IDLE) && !infl_q && room;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    logic             drop;
    logic [LEN_W-1:0] ofs;
    logic [ENT_W-1:0] ent;
    status_e          st;

    drop = 1'b0;
    ofs  = '0;
    ent  = entries_q;
    st   = ST_PUSHED;

    state_d      = state_q;
    write_slot_d = write_slot_q;
    read_slot_d  = read_slot_q;
    entries_d    = entries_q;
    dropped_d    = dropped_q;
    push_ofs_d   = push_ofs_q;
    push_act_d   = push_act_q;
    infl_d       = 1'b0;
    infl_last_d  = infl_last_q;
    pop_slot_d   = pop_slot_q;
    len_d        = len_q;
    idx_d        = idx_q;

    mem_ctl    = '0;
    byte_waddr = {write_slot_q, push_ofs_q[OFS_W-1:0]};
    byte_raddr = {pop_slot_q, idx_q[OFS_W-1:0]};
    len_waddr  = write_slot_q;
    len_wdata  = push_ofs_q;

    res_wr            = 1'b0;
    res_w.out_byte    = '0;
    res_w.msg_length  = '0;
    res_w.last        = 1'b1;
    res_w.status      = ST_DATA;
    res_w.entry_count = ENTCNT_W'(entries_q);
    res_w.ovf_count   = dropped_q;

    // A byte read issued last cycle lands here as a data word.
    if (infl_q) begin
      res_wr           = 1'b1;
      res_w.out_byte   = byte_rdata;
      res_w.msg_length = MSGLEN_W'(len_q);
      res_w.last       = infl_last_q;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_wr = 1'b1;
          case (func)
            FN_PUSH: begin
              if (!push_act_q) begin
                drop = (entries_q == ENT_W'(DEPTH));
                ofs  = '0;
              end else begin
                ofs  = push_ofs_q;
              end
              if (drop) begin
                read_slot_d = next_slot(read_slot_q);
                ent         = entries_q - ENT_W'(1);
                if (dropped_q != {OVF_W{1'b1}}) begin
                  dropped_d = dropped_q + OVF_W'(1);
                end
              end
              if (in_has) begin
                if (ofs < LEN_W'(MSG_BYTES)) begin
                  mem_ctl.byte_we = 1'b1;
                  byte_waddr      = {write_slot_q, ofs[OFS_W-1:0]};
                  ofs             = ofs + LEN_W'(1);
                end else begin
                  st = ST_TRUNC;
                end
              end
              if (in_last) begin
                mem_ctl.len_we = 1'b1;
                len_waddr      = write_slot_q;
                len_wdata      = ofs;
                write_slot_d   = next_slot(write_slot_q);
                ent            = ent + ENT_W'(1);
                push_act_d     = 1'b0;
                push_ofs_d     = '0;
              end else begin
                push_act_d     = 1'b1;
                push_ofs_d     = ofs;
              end
              entries_d         = ent;
              res_w.status      = st;
              res_w.entry_count = ENTCNT_W'(ent);
              res_w.ovf_count   = dropped_d;
            end
            FN_POP: begin
              if (entries_q == '0) begin
                res_w.status = ST_EMPTY;
              end else begin
                // The word for a pop is written once the length is known.
                res_wr         = 1'b0;
                mem_ctl.len_re = 1'b1;
                pop_slot_d     = read_slot_q;
                read_slot_d    = next_slot(read_slot_q);
                entries_d      = entries_q - ENT_W'(1);
                state_d        = S_LEN;
              end
            end
            FN_READ_OVF: begin
              res_w.status = ST_OVERFLOW;
              dropped_d    = '0;
            end
            FN_CLEAR: begin
              write_slot_d      = '0;
              read_slot_d       = '0;
              entries_d         = '0;
              dropped_d         = '0;
              push_ofs_d        = '0;
              push_act_d        = 1'b0;
              res_w.status      = ST_CLEARED;
              res_w.entry_count = '0;
              res_w.ovf_count   = '0;
            end
            default: begin
              res_wr = 1'b0;
            end
          endcase
        end
      end
      S_LEN: begin
        len_d = len_rdata;
        idx_d = '0;
        if (len_rdata == '0) begin
          if (room) begin
            res_wr  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_BYTES;
        end
      end
      S_BYTES: begin
        if (room) begin
          mem_ctl.byte_re = 1'b1;
          infl_d          = 1'b1;
          infl_last_d     = ((idx_q + LEN_W'(1)) == len_q);
          idx_d           = idx_q + LEN_W'(1);
          if ((idx_q + LEN_W'(1)) == len_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      write_slot_q <= '0;
      read_slot_q  <= '0;
      entries_q    <= '0;
      dropped_q    <= '0;
      push_ofs_q   <= '0;
      push_act_q   <= 1'b0;
      infl_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      write_slot_q <= write_slot_d;
      read_slot_q  <= read_slot_d;
      entries_q    <= entries_d;
      dropped_q    <= dropped_d;
      push_ofs_q   <= push_ofs_d;
      push_act_q   <= push_act_d;
      infl_q       <= infl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    infl_last_q <= infl_last_d;
    pop_slot_q  <= pop_slot_d;
    len_q       <= len_d;
    idx_q       <= idx_d;
  end

  mfo_store #(
    .DEPTH  (DEPTH),
    .SLOT_W (SLOT_W),
    .OFS_W  (OFS_W),
    .LEN_W  (LEN_W)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (mem_ctl),
    .byte_waddr_i (byte_waddr),
    .byte_wdata_i (in_byte),
    .byte_raddr_i (byte_raddr),
    .byte_rdata_o (byte_rdata),
    .len_waddr_i  (len_waddr),
    .len_wdata_i  (len_wdata),
    .len_raddr_i  (read_slot_q),
    .len_rdata_o  (len_rdata)
  );

  mfo_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .wdata_i (res_w),
    .ready_i (m_axis_tready),
    .valid_o (res_valid),
    .rdata_o (res_r),
    .cnt_o   (res_cnt)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {6'd0, res_r.ovf_count, res_r.entry_count,
                          res_r.msg_length, res_r.out_byte};
  assign m_axis_tuser  = res_r.status;
  assign m_axis_tlast  = res_r.last;

endmodule

FILE: sv/mfo_store.sv
// Message storage: byte memory and length memory, both with registered reads.
// Depends on mfo_pkg for the memory control struct.
module mfo_store import mfo_pkg::*; #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned SLOT_W = 3,
  parameter int unsigned OFS_W  = 5,
  parameter int unsigned LEN_W  = 6
) (
  input  logic                    clk_i,
  input  mem_ctl_t                ctl_i,
  input  logic [SLOT_W+OFS_W-1:0] byte_waddr_i,
  input  logic [7:0]              byte_wdata_i,
  input  logic [SLOT_W+OFS_W-1:0] byte_raddr_i,
  output logic [7:0]              byte_rdata_o,
  input  logic [SLOT_W-1:0]       len_waddr_i,
  input  logic [LEN_W-1:0]        len_wdata_i,
  input  logic [SLOT_W-1:0]       len_raddr_i,
  output logic [LEN_W-1:0]        len_rdata_o
);

  localparam int unsigned BYTE_DEPTH = DEPTH << OFS_W;

  logic [7:0]       byte_mem [BYTE_DEPTH];
  logic [LEN_W-1:0] len_mem  [DEPTH];
  logic [7:0]       byte_rdata_q;
  logic [LEN_W-1:0] len_rdata_q;

  // Read data holds while no read is issued, so a stalled consumer keeps it.
  always_ff @(posedge clk_i) begin
    if (ctl_i.byte_we) begin
      byte_mem[byte_waddr_i] <= byte_wdata_i;
    end
    if (ctl_i.byte_re) begin
      byte_rdata_q <= byte_mem[byte_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.len_we) begin
      len_mem[len_waddr_i] <= len_wdata_i;
    end
    if (ctl_i.len_re) begin
      len_rdata_q <= len_mem[len_raddr_i];
    end
  end

  assign byte_rdata_o = byte_rdata_q;
  assign len_rdata_o  = len_rdata_q;

endmodule

FILE: sv/mfo_resq.sv
// Two-word result queue that decouples the output port from the controller.
// Depends on mfo_pkg for the result word type.
module mfo_resq import mfo_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  res_t       wdata_i,
  input  logic       ready_i,
  output logic       valid_o,
  output res_t       rdata_o,
  output logic [1:0] cnt_o
);

  res_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o & ready_i;
  assign rdata_o = slot_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, wr_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: sv/mfo_checker.sv
// Port-level checks on the message queue output, bound to the top level.
// Depends on mfo_pkg and message_fifo_overwrite_oldest_assert.svh.
`include "message_fifo_overwrite_oldest_assert.svh"

module mfo_checker import mfo_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input logic                   m_axis_tlast
);

  // A word the sink has not taken stays put.
  `MFO_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")

  // Every status word is the only word of its item and carries no byte or length.
  `MFO_ASSERT_SAME(a_status_word, m_axis_tvalid && (m_axis_tuser != ST_DATA), m_axis_tlast && (m_axis_tdata[13:0] == 14'd0), "status word with byte, length or no last mark")

  // After a clear the queue and the overflow count are both empty.
  `MFO_ASSERT_SAME(a_cleared, m_axis_tvalid && (m_axis_tuser == ST_CLEARED), m_axis_tdata[25:14] == 12'd0, "clear word reports entries or overflows")

  // An empty pop can only come from a queue with no entries.
  `MFO_ASSERT_SAME(a_empty_pop, m_axis_tvalid && (m_axis_tuser == ST_EMPTY), m_axis_tdata[17:14] == 4'd0, "empty pop reports entries")

endmodule

bind message_fifo_overwrite_oldest mfo_checker u_mfo_checker (.*);

FILE: tb/sv/tb_message_fifo_overwrite_oldest.sv
`timescale 1ns / 100ps
// Self-checking testbench for the overwrite-oldest message queue.
// Depends on mfo_pkg and message_fifo_overwrite_oldest; a behavioral queue model predicts
// every result word, and a directed table precedes constrained-by-hand random traffic.
module tb_message_fifo_overwrite_oldest;
  import mfo_pkg::*;

  localparam int unsigned DEPTH       = 8;
  localparam int unsigned MSG_BYTES   = 32;
  localparam int unsigned TOTAL_WORDS = 310;
  localparam int unsigned CALM_WORDS  = 40;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 48;

  typedef struct {
    func_e       fn;
    logic [7:0]  data;
    bit          has;
    bit          lst;
    int unsigned rep;
    bit          typed;
    res_t        want;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [7:0] data_byte
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;  // [1:0] func, [2] has_byte
  logic                   s_axis_tlast  = 1'b0;  // last_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [7:0] out_byte, [13:8] msg_length, [17:14] entry_count,
  // [25:18] overflow_count, [31:26] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;  // [2:0] status
  logic                   m_axis_tlast;  // last_result

  // Queue model state.
  logic [7:0]          msg_mem [DEPTH][MSG_BYTES];
  logic [MSGLEN_W-1:0] msg_len [DEPTH];
  int unsigned         wr_slot, rd_slot, held, drops, fill;
  bit                  in_msg;

  res_t        pending_replies[$];
  res_t        head_reply;
  dir_row_t    dir_rows[$];
  bit          gaps_on = 1'b1;
  int unsigned hold_left;
  int unsigned idle_cycles;
  int unsigned fail_cnt;
  int unsigned words_sent, words_checked, popped_bytes, trunc_total, drop_total;

  message_fifo_overwrite_oldest #(
    .DEPTH     (DEPTH),
    .MSG_BYTES (MSG_BYTES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned wrap_next(int unsigned s);
    return (s == DEPTH - 1) ? 0 : s + 1;
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  function automatic bit rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Applies one accepted word to the model and returns the result words it causes.
  task automatic predict_queue_op(input func_e fn, input logic [7:0] d, input bit has,
                                  input bit lst, output res_t rs[$]);
    res_t        r;
    int unsigned slot, len;
    rs = {};
    r.out_byte   = '0;
    r.msg_length = '0;
    r.last       = 1'b1;
    r.status     = ST_PUSHED;
    case (fn)
      FN_PUSH: begin
        // The first word of a message on a full queue frees a slot by dropping the oldest entry.
        if (!in_msg) begin
          if (held == DEPTH) begin
            rd_slot = wrap_next(rd_slot);
            held--;
            if (drops != 255) drops++;
            drop_total++;
          end
          in_msg = 1'b1;
          fill   = 0;
        end
        if (has) begin
          if (fill < MSG_BYTES) begin
            msg_mem[wr_slot][fill] = d;
            fill++;
          end else begin
            r.status = ST_TRUNC;
            trunc_total++;
          end
        end
        if (lst) begin
          msg_len[wr_slot] = MSGLEN_W'(fill);
          wr_slot = wrap_next(wr_slot);
          held++;
          in_msg = 1'b0;
          fill   = 0;
        end
        r.entry_count = ENTCNT_W'(held);
        r.ovf_count   = OVF_W'(drops);
        rs.push_back(r);
      end
      FN_POP: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
          r.entry_count = ENTCNT_W'(held);
          r.ovf_count   = OVF_W'(drops);
          rs.push_back(r);
        end else begin
          slot    = rd_slot;
          len     = msg_len[slot];
          rd_slot = wrap_next(rd_slot);
          held--;
          r.status      = ST_DATA;
          r.entry_count = ENTCNT_W'(held);
          r.ovf_count   = OVF_W'(drops);
          if (len == 0) begin
            rs.push_back(r);
          end else begin
            for (int unsigned i = 0; i < len; i++) begin
              r.out_byte   = msg_mem[slot][i];
              r.msg_length = MSGLEN_W'(len);
              r.last       = (i == len - 1);
              rs.push_back(r);
              popped_bytes++;
            end
          end
        end
      end
      FN_READ_OVF: begin
        r.status      = ST_OVERFLOW;
        r.entry_count = ENTCNT_W'(held);
        r.ovf_count   = OVF_W'(drops);
        drops = 0;
        rs.push_back(r);
      end
      default: begin
        wr_slot = 0;
        rd_slot = 0;
        held    = 0;
        drops   = 0;
        fill    = 0;
        in_msg  = 1'b0;
        r.status      = ST_CLEARED;
        r.entry_count = '0;
        r.ovf_count   = '0;
        rs.push_back(r);
      end
    endcase
  endtask

  // Called and returning at a falling edge; holds the word until it is taken.
  task automatic send_word(input func_e fn, input logic [7:0] d, input bit has, input bit lst,
                           input bit typed, input res_t want);
    res_t replies[$];
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= {has, fn};
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_queue_op(fn, d, has, lst, replies);
    if (typed) begin
      pending_replies.push_back(want);
    end else begin
      foreach (replies[i]) pending_replies.push_back(replies[i]);
    end
    words_sent++;
    @(negedge clk_i);
  endtask

  function automatic dir_row_t mk_row(func_e fn, logic [7:0] d, bit has, bit lst,
                                      int unsigned rep, bit typed, status_e st,
                                      logic [ENTCNT_W-1:0] ent, logic [OVF_W-1:0] ovf);
    dir_row_t row;
    row.fn    = fn;
    row.data  = d;
    row.has   = has;
    row.lst   = lst;
    row.rep   = rep;
    row.typed = typed;
    row.want.out_byte    = '0;
    row.want.msg_length  = '0;
    row.want.last        = 1'b1;
    row.want.status      = st;
    row.want.entry_count = ent;
    row.want.ovf_count   = ovf;
    return row;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_cnt++;
    end
  endfunction

  // Result sink with random back-pressure bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      hold_left     <= $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result word: tdata %h, tuser %h, tlast %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fail_cnt++;
      end else begin
        head_reply = pending_replies.pop_front();
        check_field("out_byte", head_reply.out_byte, m_axis_tdata[7:0]);
        check_field("msg_length", head_reply.msg_length, m_axis_tdata[13:8]);
        check_field("entry_count", head_reply.entry_count, m_axis_tdata[17:14]);
        check_field("overflow_count", head_reply.ovf_count, m_axis_tdata[25:18]);
        check_field("tdata padding", 0, m_axis_tdata[31:26]);
        check_field("status", head_reply.status, m_axis_tuser);
        check_field("last_result", head_reply.last, m_axis_tlast);
        words_checked++;
      end
    end
  end

  // A run with no word moving on either side for too long is hung.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Queue stalled for %0d cycles with %0d result words outstanding",
               idle_cycles, pending_replies.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned pick, len;
    wr_slot = 0;
    rd_slot = 0;
    held    = 0;
    drops   = 0;
    fill    = 0;
    in_msg  = 1'b0;

    dir_rows.push_back(mk_row(FN_POP,      8'h00, 0, 0, 1, 1, ST_EMPTY,    0, 0));
    dir_rows.push_back(mk_row(FN_READ_OVF, 8'h00, 0, 0, 1, 1, ST_OVERFLOW, 0, 0));
    // Message with no bytes, then its pop.
    dir_rows.push_back(mk_row(FN_PUSH,     8'hFF, 0, 1, 1, 1, ST_PUSHED,   1, 0));
    dir_rows.push_back(mk_row(FN_POP,      8'h00, 0, 0, 1, 1, ST_DATA,     0, 0));
    dir_rows.push_back(mk_row(FN_PUSH,     8'hFF, 1, 0, 1, 0, ST_DATA,     0, 0));
    dir_rows.push_back(mk_row(FN_PUSH,     8'h00, 1, 1, 1, 0, ST_DATA,     0, 0));
    // A pop while a message is half pushed is served from committed entries.
    dir_rows.push_back(mk_row(FN_PUSH,     8'hA5, 1, 0, 1, 0, ST_DATA,     0, 0));
    dir_rows.push_back(mk_row(FN_POP,      8'h00, 0, 0, 1, 0, ST_DATA,     0, 0));
    dir_rows.push_back(mk_row(FN_PUSH,     8'h5A, 1, 1, 1, 0, ST_DATA,     0, 0));
    dir_rows.push_back(mk_row(FN_POP,      8'h00, 0, 0, 1, 0, ST_DATA,     0, 0));
    // Longest message plus two bytes that must be truncated.
    dir_rows.push_back(mk_row(FN_PUSH,     8'hE0, 1, 0, 33, 0, ST_DATA,    0, 0));
    dir_rows.push_back(mk_row(FN_PUSH,     8'h01, 1, 1, 1, 0, ST_DATA,     0, 0));
    dir_rows.push_back(mk_row(FN_POP,      8'h00, 0, 0, 1, 0, ST_DATA,     0, 0));
    // Nine one-byte messages: the ninth overwrites the oldest.
    dir_rows.push_back(mk_row(FN_PUSH,     8'h10, 1, 1, 9, 0, ST_DATA,     0, 0));
    dir_rows.push_back(mk_row(FN_READ_OVF, 8'h00, 0, 0, 1, 1, ST_OVERFLOW, 8, 1));
    dir_rows.push_back(mk_row(FN_PUSH,     8'h77, 1, 0, 1, 0, ST_DATA,     0, 0));
    dir_rows.push_back(mk_row(FN_POP,      8'h00, 0, 0, 1, 0, ST_DATA,     0, 0));
    dir_rows.push_back(mk_row(FN_CLEAR,    8'h00, 0, 0, 1, 1, ST_CLEARED,  0, 0));
    dir_rows.push_back(mk_row(FN_POP,      8'h00, 0, 0, 1, 1, ST_EMPTY,    0, 0));
    dir_rows.push_back(mk_row(FN_PUSH,     8'h3C, 1, 1, 1, 0, ST_DATA,     0, 0));
    dir_rows.push_back(mk_row(FN_POP,      8'h00, 0, 0, 1, 0, ST_DATA,     0, 0));

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      for (int unsigned k = 0; k < dir_rows[r].rep; k++) begin
        send_word(dir_rows[r].fn, 8'(dir_rows[r].data + k), dir_rows[r].has, dir_rows[r].lst,
                  dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // Mostly whole messages with random content, mixed with pops and the odd
    // abandoned message, stray empty push word or counter read.
    while (words_sent < TOTAL_WORDS) begin
      if (words_sent + CALM_WORDS >= TOTAL_WORDS) gaps_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 52) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
        for (int unsigned i = 0; i < len; i++) begin
          if ($urandom_range(0, 12) == 0) send_word(FN_POP, rnd_byte(), 0, 0, 0, '0);
          if ($urandom_range(0, 15) == 0) send_word(FN_PUSH, rnd_byte(), 0, 0, 0, '0);
          if ($urandom_range(0, 40) == 0) begin
            send_word(FN_CLEAR, rnd_byte(), rnd_bit(), rnd_bit(), 0, '0);
            break;
          end
          send_word(FN_PUSH, rnd_byte(), 1, 0, 0, '0);
        end
        send_word(FN_PUSH, rnd_byte(), rnd_bit(), 1, 0, '0);
      end else if (pick < 80) begin
        send_word(FN_POP, rnd_byte(), rnd_bit(), rnd_bit(), 0, '0);
      end else if (pick < 88) begin
        send_word(FN_READ_OVF, rnd_byte(), rnd_bit(), rnd_bit(), 0, '0);
      end else if (pick < 91) begin
        send_word(FN_CLEAR, rnd_byte(), rnd_bit(), rnd_bit(), 0, '0);
      end else begin
        send_word(FN_PUSH, rnd_byte(), rnd_bit(), rnd_bit(), 0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d words and checked %0d result words, including %0d popped bytes,",
             words_sent, words_checked, popped_bytes);
    $display("%0d truncated push bytes and %0d entries dropped on a full queue.",
             trunc_total, drop_total);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
